// File: src/cbs_shaper_parameter_calc_assert.svh
// assertion macros for the shaper parameter calculator
`ifndef CBS_SHAPER_PARAMETER_CALC_ASSERT_SVH
`define CBS_SHAPER_PARAMETER_CALC_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/cbs_pkg.sv
`default_nettype none
package cbs_pkg;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_PORT_RATE = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_GEN_FRAME = 3'd4;
  localparam logic [30:0] PORT_RATE_RST = 31'd1000000;
  localparam logic [15:0] GEN_FRAME_RST = 16'd1522;
  localparam int DIV_W = 64;
  localparam int CNT_W = 7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LO_START, ST_LO_WAIT, ST_GQ_START, ST_GQ_WAIT, ST_MUL_H, ST_MUL_L,
    ST_HI, ST_T1_START, ST_T1_WAIT, ST_T2_START, ST_T2_WAIT, ST_UPD, ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [DIV_W-1:0] num;
    logic [31:0]     den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: src/cbs_div.sv
`default_nettype none
module cbs_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cbs_pkg::div_req_t req,
  output cbs_pkg::div_rsp_t      rsp
);
  import cbs_pkg::*;

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0]      trial;
  logic [32:0]      shifted;

  // restoring divider, one quotient bit a cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[31:0], quo_r[DIV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule
`default_nettype wire

// File: src/cbs_shaper_parameter_calc.sv
`default_nettype none
// credit-based shaper parameter calculator
// input channel: in_valid/in_stall with class_bitrate, class_max_frame, first_class,
// one traffic class per transaction in priority order; first_class clears the
// running interference time before the class is computed
// output channel: out_valid/out_stall with idle_slope, send_slope, lo_credit,
// hi_credit and calc_error, one result transaction per input transaction
// config port: apb-style, port_rate at 0x0, general_max_frame at 0x4, pready high;
// write only while idle
// computation: four serial divisions through one shared restoring divider and
// the sequencing states between them
// in_stall is high while a class is computed, and no new class is accepted
// reset: registers return to 1000000 and 1522, interference time clears
// a stalled result holds in the output register while the next class computes;
// if it is still stalled when that class is done, the block waits with in_stall high
module cbs_shaper_parameter_calc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [30:0] in_class_bitrate,
  input  wire logic [15:0] in_class_max_frame,
  input  wire logic        in_first_class,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_idle_slope,
  output logic [31:0]      out_send_slope,
  output logic [31:0]      out_lo_credit,
  output logic [30:0]      out_hi_credit,
  output logic             out_calc_error,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [cbs_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import cbs_pkg::*;

  state_t state_r, state_nxt;
  logic [30:0] rate_r, gen_r, b_r;
  logic [15:0] f_r;
  logic [63:0] t_r, t_nxt, sum_r, acc_r, term_r;
  logic [31:0] lo_r;
  logic [30:0] hi_r;
  logic        err_r, neg_r, out_valid_r;
  logic [30:0] out_idle_r, out_hi_r;
  logic [31:0] out_send_r, out_lo_r;
  logic        out_err_r, out_ld;
  logic [31:0] send_s;
  logic [31:0] d;
  logic [47:0] mag;
  logic [63:0] prod;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        in_acc, wr;

  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr)
      ADDR_PORT_RATE: cfg_prdata = {1'b0, rate_r};
      ADDR_GEN_FRAME: cfg_prdata = {16'd0, gen_r[15:0]};
      default:        cfg_prdata = '0;
    endcase
  end

  assign d      = (rate_r == '0) ? 32'd1 : {1'b0, rate_r};
  assign send_s = {1'b0, b_r} - {1'b0, rate_r};
  assign in_acc = in_valid & ~in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_ld = (state_r == ST_OUT) & ~(out_valid_r & out_stall);

  cbs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_LO_START;
      ST_LO_START: state_nxt = ST_LO_WAIT;
      ST_LO_WAIT:  if (drsp.done) state_nxt = ST_GQ_START;
      ST_GQ_START: state_nxt = ST_GQ_WAIT;
      ST_GQ_WAIT:  if (drsp.done) state_nxt = ST_MUL_H;
      ST_MUL_H:    state_nxt = ST_MUL_L;
      ST_MUL_L:    state_nxt = ST_HI;
      ST_HI:       state_nxt = ST_T1_START;
      ST_T1_START: state_nxt = ST_T1_WAIT;
      ST_T1_WAIT:  if (drsp.done) state_nxt = ST_T2_START;
      ST_T2_START: state_nxt = ST_T2_WAIT;
      ST_T2_WAIT:  if (drsp.done) state_nxt = ST_UPD;
      ST_UPD:      state_nxt = ST_OUT;
      ST_OUT:      if (!(out_valid_r && out_stall)) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    dreq = '0;
    mag  = 48'({16'd0, rate_r} - {16'd0, b_r}) * 48'(f_r);
    case (state_r)
      ST_LO_START: begin
        dreq.start = 1'b1;
        dreq.num   = neg_r ? 64'(mag) + 64'(d) - 64'd1 : 64'(48'(f_r) * 48'(b_r - rate_r));
        dreq.den   = d;
      end
      ST_GQ_START: begin
        dreq.start = 1'b1;
        dreq.num   = {1'b0, gen_r, 32'd0};
        dreq.den   = d;
      end
      ST_T1_START: begin
        dreq.start = 1'b1;
        dreq.num   = {1'b0, hi_r, 32'd0};
        dreq.den   = {1'b0, rate_r - b_r};
      end
      ST_T2_START: begin
        dreq.start = 1'b1;
        dreq.num   = {16'd0, f_r, 32'd0};
        dreq.den   = d;
      end
      default: dreq = '0;
    endcase
  end

  assign prod = (state_r == ST_MUL_H) ? 64'(b_r) * 64'(sum_r[63:32])
                                      : 64'(b_r) * 64'(sum_r[31:0]);

  always_comb begin
    t_nxt = t_r + term_r;
    if (t_nxt < t_r) t_nxt = '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= PORT_RATE_RST;
      gen_r       <= 31'(GEN_FRAME_RST);
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr && cfg_paddr == ADDR_PORT_RATE) rate_r <= cfg_pwdata[30:0];
      if (wr && cfg_paddr == ADDR_GEN_FRAME) gen_r <= {15'd0, cfg_pwdata[15:0]};
      if (in_acc && in_first_class) t_r <= '0;
      if (state_r == ST_UPD) t_r <= t_nxt;
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
    if (in_acc) begin
      b_r   <= in_class_bitrate;
      f_r   <= in_class_max_frame;
      neg_r <= in_class_bitrate < rate_r;
      err_r <= ~(in_class_bitrate < rate_r);
    end
    if (out_ld) begin
      out_idle_r <= b_r;
      out_send_r <= send_s;
      out_lo_r   <= lo_r;
      out_hi_r   <= hi_r;
      out_err_r  <= err_r;
    end
    case (state_r)
      ST_LO_WAIT: if (drsp.done) begin
        if (neg_r) begin
          if (drsp.quo > 64'h8000_0000) begin
            lo_r <= 32'h8000_0000;
            err_r <= 1'b1;
          end else lo_r <= 32'(~drsp.quo + 64'd1);
        end else if (drsp.quo > 64'h7FFF_FFFF) begin
          lo_r <= 32'h7FFF_FFFF;
          err_r <= 1'b1;
        end else lo_r <= drsp.quo[31:0];
      end
      ST_GQ_WAIT: if (drsp.done) begin
        sum_r <= (t_r + drsp.quo < t_r) ? '1 : t_r + drsp.quo;
      end
      ST_MUL_H: acc_r <= prod;
      ST_MUL_L: acc_r <= acc_r + 64'(prod[63:32]) + 64'(prod[31:0] != 32'd0);
      ST_HI: begin
        if (acc_r > 64'h7FFF_FFFF) begin
          hi_r  <= 31'h7FFF_FFFF;
          err_r <= 1'b1;
        end else hi_r <= acc_r[30:0];
      end
      ST_T1_WAIT: if (drsp.done) term_r <= neg_r ? drsp.quo : '1;
      ST_T2_WAIT: if (drsp.done) begin
        term_r <= (term_r + drsp.quo < term_r) ? '1 : term_r + drsp.quo;
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_idle_slope = out_idle_r;
  assign out_send_slope = out_send_r;
  assign out_lo_credit  = out_lo_r;
  assign out_hi_credit  = out_hi_r;
  assign out_calc_error = out_err_r;

`include "cbs_shaper_parameter_calc_assert.svh"
  `CBS_ASSERT_IMPL(a_busy_stall, clk, rst_n, state_r != ST_IDLE, in_stall)
  `CBS_ASSERT_NEXT(a_out_after_calc, clk, rst_n, state_r == ST_OUT, out_valid)
  `CBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire
